/* sv/assert_macros.svh */
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication checked on every clock edge out of reset.
`define MCSR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcsr check failed");

// Next-cycle implication checked on every clock edge out of reset.
`define MCSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcsr check failed");

`endif

/* sv/mcsr_pkg.sv */
// Package with types, codes and constants of the setting ramp.
package mcsr_pkg;

  localparam int CHANNELS_DEF = 16;
  localparam int CH_W = 4;
  localparam logic [15:0] BOOT_HOLD_RST = 16'd5000;

  // Input operation codes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_CANCEL = 2'd3;

  // Result kinds
  localparam logic [1:0] K_BOOT = 2'd0;
  localparam logic [1:0] K_STEP = 2'd1;
  localparam logic [1:0] K_RUN  = 2'd2;
  localparam logic [1:0] K_DONE = 2'd3;

  typedef struct packed {
    logic        enabled;
    logic [7:0]  boot_eq;
    logic [6:0]  boot_gain;
    logic [2:0]  boot_bias;
    logic [7:0]  run_eq;
    logic [6:0]  run_gain;
    logic [2:0]  run_bias;
    logic [15:0] step_ticks;
    logic [15:0] delay_ticks;
  } row_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [CH_W-1:0] channel;
    logic            power_up;
    logic [7:0]      eq_byte;
    logic [6:0]      gain_byte;
    logic [2:0]      bias_level;
    logic            last;
  } res_t;

  typedef struct packed {
    logic [7:0] eq_byte;
    logic [6:0] gain_byte;
    logic [2:0] bias_level;
    logic [3:0] span;
  } step_img_t;

endpackage

/* sv/mcsr_in_if.sv */
// Input channel interface: operation word with its table row fields.
interface mcsr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [3:0]  channel;
  logic        enabled;
  logic [7:0]  boot_eq_byte;
  logic [6:0]  boot_gain_byte;
  logic [2:0]  boot_bias;
  logic [7:0]  run_eq_byte;
  logic [6:0]  run_gain_byte;
  logic [2:0]  run_bias;
  logic [15:0] step_ticks;
  logic [15:0] delay_ticks;

  modport source (output valid, op, channel, enabled, boot_eq_byte, boot_gain_byte,
                  boot_bias, run_eq_byte, run_gain_byte, run_bias, step_ticks,
                  delay_ticks, input ready);
  modport sink (input valid, op, channel, enabled, boot_eq_byte, boot_gain_byte,
                boot_bias, run_eq_byte, run_gain_byte, run_bias, step_ticks,
                delay_ticks, output ready);
endinterface

/* sv/mcsr_out_if.sv */
// Result channel interface: one register write word per handshake.
interface mcsr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] out_channel;
  logic       power_up;
  logic [7:0] eq_byte;
  logic [6:0] gain_byte;
  logic [2:0] bias_level;
  logic       last;

  modport source (output valid, kind, out_channel, power_up, eq_byte, gain_byte,
                  bias_level, last, input ready);
  modport sink (input valid, kind, out_channel, power_up, eq_byte, gain_byte,
                bias_level, last, output ready);
endinterface

/* sv/mcsr_table.sv */
// Channel table: one row per channel, written by load, read by the sequencer.
module mcsr_table
  import mcsr_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  row_t             wdata,
  input  logic [IDX_W-1:0] raddr,
  output row_t             rdata
);

  row_t rows_r [CHANNELS];

  // Write one row on a load, register the addressed row
  always_ff @(posedge clk) begin
    if (we) begin
      rows_r[waddr] <= wdata;
    end
    rdata <= rows_r[raddr];
  end

endmodule

/* sv/mcsr_walk.sv */
// Shared step unit: ramp images and largest field distance of one channel.
module mcsr_walk
  import mcsr_pkg::*;
(
  input  row_t       row,
  input  logic [4:0] step,
  output step_img_t  img
);

  function automatic logic [3:0] walk(input logic [3:0] from, input logic [3:0] to,
                                      input logic [4:0] s);
    logic [5:0] up;
    logic [3:0] gap;
    begin
      up  = {2'b00, from} + {1'b0, s};
      gap = from - to;
      if (to >= from) walk = (up > {2'b00, to}) ? to : up[3:0];
      else walk = ({1'b0, gap} <= s) ? to : 4'(from - s[3:0]);
    end
  endfunction

  function automatic logic [3:0] mag_gap(input logic [3:0] a, input logic [3:0] b);
    mag_gap = (a >= b) ? a - b : b - a;
  endfunction

  logic [3:0] s1, s2, pr, fg, bi;
  logic [3:0] d1, d2, d3, d4, d5, m1, m2, m3;

  // Walk every magnitude toward its run value
  assign s1 = walk(row.boot_eq[6:3], row.run_eq[6:3], step);
  assign s2 = walk({1'b0, row.boot_eq[2:0]}, {1'b0, row.run_eq[2:0]}, step);
  assign pr = walk(row.boot_gain[6:3], row.run_gain[6:3], step);
  assign fg = walk({1'b0, row.boot_gain[2:0]}, {1'b0, row.run_gain[2:0]}, step);
  assign bi = walk({1'b0, row.boot_bias}, {1'b0, row.run_bias}, step);

  // Largest distance over the fields
  assign d1 = mag_gap(row.boot_eq[6:3], row.run_eq[6:3]);
  assign d2 = mag_gap({1'b0, row.boot_eq[2:0]}, {1'b0, row.run_eq[2:0]});
  assign d3 = mag_gap(row.boot_gain[6:3], row.run_gain[6:3]);
  assign d4 = mag_gap({1'b0, row.boot_gain[2:0]}, {1'b0, row.run_gain[2:0]});
  assign d5 = mag_gap({1'b0, row.boot_bias}, {1'b0, row.run_bias});
  assign m1 = (d1 > d2) ? d1 : d2;
  assign m2 = (d3 > d4) ? d3 : d4;
  assign m3 = (m1 > m2) ? m1 : m2;

  assign img.eq_byte    = {row.boot_eq[7] & row.run_eq[7], s1, s2[2:0]};
  assign img.gain_byte  = {pr, fg[2:0]};
  assign img.bias_level = bi[2:0];
  assign img.span       = (m3 > d5) ? m3 : d5;

endmodule

/* sv/multi_channel_setting_ramp.sv */
// Top level: sequencer, per-channel ramp state, result staging and checks.
// A load or a cancel completes in the idle state, as does a tick while no ramp runs.
// A start or a tick visits one channel per cycle through the shared step unit while
// the result register is empty or taken; a tick that completes the ramp then visits
// every channel again in the run state and ends with a done word. Input is ready only
// between items. One result is held back in a pending stage so the final word of an
// item carries last.
`include "assert_macros.svh"
module multi_channel_setting_ramp
  import mcsr_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  mcsr_in_if.sink     in_ch,
  mcsr_out_if.source  out_ch
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CHANNELS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_TICK  = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             any_r, any_nxt;
  logic             running_r, running_nxt;
  logic [15:0]      hold_r;
  logic             pend_valid_r, pend_valid_nxt;
  res_t             pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_r, out_nxt;

  logic             busy_r [CHANNELS];
  logic [4:0]       sidx_r [CHANNELS];
  logic [17:0]      cnt_r  [CHANNELS];

  logic             accept, can_adv, clear_all;
  logic             chw_en, chw_busy;
  logic [4:0]       chw_sidx;
  logic [17:0]      chw_cnt, cnt_dec;
  logic             new_valid, push, push_last;
  res_t             new_res;
  row_t             load_row, row;
  step_img_t        img;
  logic [CH_W-1:0]  ch_out;
  logic [IDX_W-1:0] idx_inc;

  assign accept  = in_ch.valid && in_ch.ready;
  assign can_adv = !out_valid_r || out_ch.ready;
  assign ch_out  = CH_W'(idx_r);
  assign idx_inc = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
  assign in_ch.ready = (state_r == S_IDLE);

  assign load_row = '{enabled: in_ch.enabled, boot_eq: in_ch.boot_eq_byte,
                      boot_gain: in_ch.boot_gain_byte, boot_bias: in_ch.boot_bias,
                      run_eq: in_ch.run_eq_byte, run_gain: in_ch.run_gain_byte,
                      run_bias: in_ch.run_bias, step_ticks: in_ch.step_ticks,
                      delay_ticks: in_ch.delay_ticks};

  // Read address is idx_nxt, so the registered row arrives together with idx_r
  mcsr_table #(.CHANNELS(CHANNELS)) u_table (
    .clk   (clk),
    .we    (accept && in_ch.op == OP_LOAD && {1'b0, in_ch.channel} < 5'(CHANNELS)),
    .waddr (in_ch.channel[IDX_W-1:0]),
    .wdata (load_row),
    .raddr (idx_nxt),
    .rdata (row)
  );

  mcsr_walk u_walk (
    .row  (row),
    .step (sidx_r[idx_r]),
    .img  (img)
  );

  assign cnt_dec = (cnt_r[idx_r] != 18'd0) ? cnt_r[idx_r] - 18'd1 : 18'd0;

  // Sequence one channel per cycle while the result can advance, and form its result
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    any_nxt     = any_r;
    running_nxt = running_r;
    clear_all   = 1'b0;
    chw_en      = 1'b0;
    chw_busy    = 1'b0;
    chw_sidx    = 5'd0;
    chw_cnt     = 18'd0;
    new_valid   = 1'b0;
    new_res     = '0;
    push        = 1'b0;
    push_last   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          any_nxt = 1'b0;
          unique case (in_ch.op)
            OP_START:  state_nxt = S_START;
            OP_TICK:   if (running_r) state_nxt = S_TICK;
            OP_CANCEL: begin
              clear_all   = 1'b1;
              running_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_START: begin
        if (can_adv) begin
          new_valid        = 1'b1;
          new_res.kind     = K_BOOT;
          new_res.channel  = ch_out;
          chw_en           = 1'b1;
          if (row.enabled) begin
            new_res.power_up   = 1'b1;
            new_res.eq_byte    = row.boot_eq;
            new_res.gain_byte  = row.boot_gain;
            new_res.bias_level = row.boot_bias;
            chw_busy = 1'b1;
            chw_sidx = 5'd1;
            chw_cnt  = 18'(hold_r) + 18'(row.delay_ticks) + 18'(row.step_ticks);
          end
          idx_nxt = idx_inc;
          if (idx_r == IDX_LAST) begin
            running_nxt = 1'b1;
            state_nxt   = S_FLUSH;
          end
        end
      end
      S_TICK: begin
        if (can_adv) begin
          if (busy_r[idx_r]) begin
            any_nxt  = 1'b1;
            chw_en   = 1'b1;
            chw_busy = 1'b1;
            chw_sidx = sidx_r[idx_r];
            chw_cnt  = cnt_dec;
            if (cnt_dec == 18'd0) begin
              new_valid          = 1'b1;
              new_res.kind       = K_STEP;
              new_res.channel    = ch_out;
              new_res.eq_byte    = img.eq_byte;
              new_res.gain_byte  = img.gain_byte;
              new_res.bias_level = img.bias_level;
              if (sidx_r[idx_r] >= {1'b0, img.span}) begin
                chw_busy = 1'b0;
              end else begin
                chw_sidx = sidx_r[idx_r] + 5'd1;
                chw_cnt  = 18'(row.step_ticks);
              end
            end
          end
          idx_nxt = idx_inc;
          if (idx_r == IDX_LAST) begin
            state_nxt = (any_r || busy_r[idx_r]) ? S_FLUSH : S_RUN;
          end
        end
      end
      S_RUN: begin
        if (can_adv) begin
          if (row.enabled) begin
            new_valid          = 1'b1;
            new_res.kind       = K_RUN;
            new_res.channel    = ch_out;
            new_res.eq_byte    = row.run_eq;
            new_res.gain_byte  = row.run_gain;
            new_res.bias_level = row.run_bias;
          end
          idx_nxt = idx_inc;
          if (idx_r == IDX_LAST) state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (can_adv) begin
          new_valid    = 1'b1;
          new_res.kind = K_DONE;
          running_nxt  = 1'b0;
          state_nxt    = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (can_adv) begin
          push      = pend_valid_r;
          push_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (new_valid) push = pend_valid_r;
  end

  // Stage results: a new word parks in pending, the older one moves to the output
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_nxt        = out_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_nxt       = pend_r;
      out_nxt.last  = push_last;
      pend_valid_nxt = 1'b0;
    end
    if (new_valid) begin
      pend_valid_nxt = 1'b1;
      pend_nxt       = new_res;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      any_r        <= 1'b0;
      running_r    <= 1'b0;
      hold_r       <= BOOT_HOLD_RST;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      any_r        <= any_nxt;
      running_r    <= running_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) hold_r <= cfg_wdata;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  // Per-channel ramp state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        busy_r[i] <= 1'b0;
        sidx_r[i] <= 5'd0;
        cnt_r[i]  <= 18'd0;
      end
    end else if (clear_all) begin
      for (int i = 0; i < CHANNELS; i++) busy_r[i] <= 1'b0;
    end else if (chw_en) begin
      busy_r[idx_r] <= chw_busy;
      sidx_r[idx_r] <= chw_sidx;
      cnt_r[idx_r]  <= chw_cnt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_r.kind;
  assign out_ch.out_channel = out_r.channel;
  assign out_ch.power_up    = out_r.power_up;
  assign out_ch.eq_byte     = out_r.eq_byte;
  assign out_ch.gain_byte   = out_r.gain_byte;
  assign out_ch.bias_level  = out_r.bias_level;
  assign out_ch.last        = out_r.last;

  // Checks
  `MCSR_ASSERT_NOW(a_idle_no_pend, state_r == S_IDLE, !pend_valid_r)
  `MCSR_ASSERT_NEXT(a_cancel_stops, accept && in_ch.op == OP_CANCEL, !running_r && !busy_r[0])
  `MCSR_ASSERT_NEXT(a_start_seq, accept && in_ch.op == OP_START, state_r == S_START)

endmodule
